### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ahtm_pkg.sv
package ahtm_pkg;

  localparam int RAW_W       = 12;
  localparam int MV_W        = 12;
  localparam int LEVEL_W     = 3;
  localparam int VIOL_W      = 2;
  localparam int CFG_INDEX_W = 8;

  localparam int SAMPLE_COUNT_DEFAULT = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_NONE    = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW     = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM  = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 3'd4;

  localparam logic [VIOL_W-1:0] VIOL_NONE    = 2'd0;
  localparam logic [VIOL_W-1:0] VIOL_INHIBIT = 2'd1;
  localparam logic [VIOL_W-1:0] VIOL_STRIP   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_TH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_TH    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONE_TH   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HYST      = 8'd3;

  localparam logic [MV_W-1:0] MEDIUM_TH_RESET = 12'd198;
  localparam logic [MV_W-1:0] LOW_TH_RESET    = 12'd495;
  localparam logic [MV_W-1:0] NONE_TH_RESET   = 12'd2904;
  localparam logic [MV_W-1:0] HYST_RESET      = 12'd33;

  // avg * 3300 fits in 24 bits; / 4095 by exact reciprocal, shift 24 + 12
  localparam int PROD_W   = 24;
  localparam int MV_SHIFT = 36;
  localparam int MV_RCP_W = 25;
  localparam logic [11:0] VDD_MV = 12'd3300;
  localparam logic [MV_RCP_W-1:0] MV_RECIP =
    MV_RCP_W'(((64'd1 << MV_SHIFT) + 64'd4094) / 64'd4095);

  typedef struct packed {
    logic [RAW_W-1:0] raw_sample;
    logic             strip_level;
  } sample_t;

  typedef struct packed {
    logic [MV_W-1:0]    millivolts;
    logic [LEVEL_W-1:0] inhibit_level;
    logic               strip_intact;
    logic [VIOL_W-1:0]  violation;
    logic               violation_changed;
  } result_t;

endpackage

### sv/ahtm_scale.sv
module ahtm_scale #(
  parameter int SAMPLE_COUNT = ahtm_pkg::SAMPLE_COUNT_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [ahtm_pkg::RAW_W+$clog2(SAMPLE_COUNT)-1:0] in_sum,
  input  logic in_pin,
  output logic out_valid,
  input  logic out_ready,
  output logic [ahtm_pkg::MV_W-1:0] out_mv,
  output logic out_pin
);

  localparam int L       = $clog2(SAMPLE_COUNT);
  localparam int SUM_W   = ahtm_pkg::RAW_W + L;
  localparam int SH      = SUM_W + L;
  localparam int RCP_W   = SUM_W + 1;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  logic                          v2, v3, v4;
  logic [ahtm_pkg::RAW_W-1:0]    avg;
  logic [ahtm_pkg::PROD_W-1:0]   prod;
  logic [ahtm_pkg::MV_W-1:0]     mv;
  logic                          pin2, pin3, pin4;
  logic                          free2, free3, free4;
  logic [SUM_W+RCP_W-1:0]        avg_wide;
  logic [ahtm_pkg::PROD_W+ahtm_pkg::MV_RCP_W-1:0] mv_wide;

  assign free4 = !v4 || out_ready;
  assign free3 = !v3 || free4;
  assign free2 = !v2 || free3;
  assign in_ready = free2;

  assign avg_wide = (SUM_W+RCP_W)'(in_sum) * (SUM_W+RCP_W)'(RECIP);
  assign mv_wide  = (ahtm_pkg::PROD_W+ahtm_pkg::MV_RCP_W)'(prod)
                  * (ahtm_pkg::PROD_W+ahtm_pkg::MV_RCP_W)'(ahtm_pkg::MV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (free2) v2 <= in_valid;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && in_valid) begin
      avg  <= avg_wide[SH +: ahtm_pkg::RAW_W];
      pin2 <= in_pin;
    end
    if (free3 && v2) begin
      prod <= ahtm_pkg::PROD_W'(avg) * ahtm_pkg::PROD_W'(ahtm_pkg::VDD_MV);
      pin3 <= pin2;
    end
    if (free4 && v3) begin
      mv   <= mv_wide[ahtm_pkg::MV_SHIFT +: ahtm_pkg::MV_W];
      pin4 <= pin3;
    end
  end

  assign out_valid = v4;
  assign out_mv    = mv;
  assign out_pin   = pin4;

endmodule

### sv/adc_level_hysteresis_tamper_monitor.sv
// A group-closing transaction passes the group register, the three-stage scaling
// pipeline behind it and the result register on its way to out_valid. Throughput:
// one sample per cycle while in_ready is high; one result per SAMPLE_COUNT samples.
// Reset (rst, synchronous): clears the sum, sample count, pipeline, level to
// unknown, last violation to none; thresholds return to their defaults.
`include "assert_macros.svh"

module adc_level_hysteresis_tamper_monitor #(
  parameter int SAMPLE_COUNT = ahtm_pkg::SAMPLE_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ahtm_pkg::sample_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ahtm_pkg::result_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ahtm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ahtm_pkg::MV_W-1:0]            cfg_data
);

  localparam int SUM_W = ahtm_pkg::RAW_W + $clog2(SAMPLE_COUNT);
  localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);

  logic [ahtm_pkg::MV_W-1:0]    medium_th, low_th, none_th, hyst;
  logic [SUM_W-1:0]             sample_sum, sample_sum_next;
  logic [IDX_W-1:0]             sample_index;
  logic                         idx_last, accept, grp_done;
  logic [SUM_W-1:0]             grp_sum;
  logic                         grp_valid, grp_pin, grp_ready;
  logic                         sc_valid, sc_ready, sc_pin;
  logic [ahtm_pkg::MV_W-1:0]    sc_mv;
  logic [ahtm_pkg::LEVEL_W-1:0] current_level, level_next;
  logic [ahtm_pkg::VIOL_W-1:0]  last_violation, viol_next;
  logic                         intact_next, free_out, grp_free;
  logic                         level_ok;

  function automatic logic [ahtm_pkg::LEVEL_W-1:0] classify(
    input logic [ahtm_pkg::MV_W-1:0]    mv,
    input logic [ahtm_pkg::LEVEL_W-1:0] prev,
    input logic [ahtm_pkg::MV_W-1:0]    th_m,
    input logic [ahtm_pkg::MV_W-1:0]    th_l,
    input logic [ahtm_pkg::MV_W-1:0]    th_n,
    input logic [ahtm_pkg::MV_W-1:0]    th_h
  );
    logic signed [13:0] tm, tl, tn, h, v;
    logic [ahtm_pkg::LEVEL_W-1:0] lvl;
    tm = signed'({2'b00, th_m});
    tl = signed'({2'b00, th_l});
    tn = signed'({2'b00, th_n});
    h  = signed'({2'b00, th_h});
    v  = signed'({2'b00, mv});
    case (prev)
      ahtm_pkg::LEVEL_HIGH: begin
        tm = tm + h;
      end
      ahtm_pkg::LEVEL_MEDIUM: begin
        tm = tm - h;
        tl = tl + h;
      end
      ahtm_pkg::LEVEL_LOW: begin
        tl = tl - h;
        tn = tn + h;
      end
      ahtm_pkg::LEVEL_NONE: begin
        tn = tn - h;
      end
      default: begin
      end
    endcase
    if (v > tn)      lvl = ahtm_pkg::LEVEL_NONE;
    else if (v > tl) lvl = ahtm_pkg::LEVEL_LOW;
    else if (v > tm) lvl = ahtm_pkg::LEVEL_MEDIUM;
    else             lvl = ahtm_pkg::LEVEL_HIGH;
    return lvl;
  endfunction

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      medium_th <= ahtm_pkg::MEDIUM_TH_RESET;
      low_th    <= ahtm_pkg::LOW_TH_RESET;
      none_th   <= ahtm_pkg::NONE_TH_RESET;
      hyst      <= ahtm_pkg::HYST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ahtm_pkg::CFG_MEDIUM_TH: medium_th <= cfg_data;
        ahtm_pkg::CFG_LOW_TH:    low_th    <= cfg_data;
        ahtm_pkg::CFG_NONE_TH:   none_th   <= cfg_data;
        ahtm_pkg::CFG_HYST:      hyst      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Accumulator; only the group-closing sample waits on the group register
  assign idx_last        = (sample_index == IDX_LAST);
  assign grp_free        = !grp_valid || grp_ready;
  assign in_ready        = !idx_last || grp_free;
  assign accept          = in_valid && in_ready;
  assign grp_done        = accept && idx_last;
  assign sample_sum_next = sample_sum + SUM_W'(in_data.raw_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_index <= '0;
      grp_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (idx_last) begin
          sample_sum   <= '0;
          sample_index <= '0;
        end else begin
          sample_sum   <= sample_sum_next;
          sample_index <= sample_index + IDX_W'(1);
        end
      end
      if (grp_free) grp_valid <= grp_done;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_done) begin
      grp_sum <= sample_sum_next;
      grp_pin <= in_data.strip_level;
    end
  end

  ahtm_scale #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (grp_valid),
    .in_ready  (grp_ready),
    .in_sum    (grp_sum),
    .in_pin    (grp_pin),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_mv    (sc_mv),
    .out_pin   (sc_pin)
  );

  // Classification and result register
  assign free_out    = !out_valid || out_ready;
  assign sc_ready    = free_out;
  assign level_next  = classify(sc_mv, current_level, medium_th, low_th, none_th, hyst);
  assign intact_next = !sc_pin;

  always_comb begin
    if ((level_next == ahtm_pkg::LEVEL_NONE) && intact_next) begin
      viol_next = ahtm_pkg::VIOL_INHIBIT;
    end else if ((level_next != ahtm_pkg::LEVEL_NONE) && !intact_next) begin
      viol_next = ahtm_pkg::VIOL_STRIP;
    end else begin
      viol_next = ahtm_pkg::VIOL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      current_level  <= ahtm_pkg::LEVEL_UNKNOWN;
      last_violation <= ahtm_pkg::VIOL_NONE;
    end else if (free_out) begin
      out_valid <= sc_valid;
      if (sc_valid) begin
        current_level  <= level_next;
        last_violation <= viol_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_out && sc_valid) begin
      out_data.millivolts        <= sc_mv;
      out_data.inhibit_level     <= level_next;
      out_data.strip_intact      <= intact_next;
      out_data.violation         <= viol_next;
      out_data.violation_changed <= (viol_next != last_violation);
    end
  end

  assign level_ok = (out_data.inhibit_level != ahtm_pkg::LEVEL_UNKNOWN)
                 && (out_data.inhibit_level <= ahtm_pkg::LEVEL_HIGH);

  `ASSERT_NOW(a_index_range, clk, rst, 1'b1, sample_index <= IDX_LAST)
  `ASSERT_NEXT(a_group_loaded, clk, rst, grp_done, grp_valid)
  `ASSERT_NOW(a_level_known, clk, rst, out_valid, level_ok)
  `ASSERT_NOW(a_viol_tracked, clk, rst, out_valid, out_data.violation == last_violation)

endmodule

### tb/testbench.sv
module testbench;
  import ahtm_pkg::*;

  localparam int SAMPLES    = SAMPLE_COUNT_DEFAULT;
  localparam int FULL_SCALE = 4095;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE     = 12;

  class reading_ledger;
    logic [MV_W-1:0]    medium_th = MEDIUM_TH_RESET;
    logic [MV_W-1:0]    low_th    = LOW_TH_RESET;
    logic [MV_W-1:0]    none_th   = NONE_TH_RESET;
    logic [MV_W-1:0]    hyst      = HYST_RESET;
    int                 sum;
    int                 count;
    logic [LEVEL_W-1:0] level     = LEVEL_UNKNOWN;
    logic [VIOL_W-1:0]  last_viol = VIOL_NONE;
    result_t            due_readings[$];
    int                 faults;

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [MV_W-1:0] val);
      case (idx)
        CFG_MEDIUM_TH: medium_th = val;
        CFG_LOW_TH:    low_th = val;
        CFG_NONE_TH:   none_th = val;
        CFG_HYST:      hyst = val;
        default: ;
      endcase
    endfunction

    function void take_sample(sample_t s);
      result_t r;
      int avg, mv, tm, tl, tn, h;
      logic [VIOL_W-1:0] viol;
      sum += s.raw_sample;
      count++;
      if (count < SAMPLES) return;
      avg = sum / SAMPLES;
      sum = 0;
      count = 0;
      mv = avg * int'(VDD_MV) / FULL_SCALE;
      tm = medium_th;
      tl = low_th;
      tn = none_th;
      h = hyst;
      case (level)
        LEVEL_HIGH:   tm += h;
        LEVEL_MEDIUM: begin
          tm -= h;
          tl += h;
        end
        LEVEL_LOW: begin
          tl -= h;
          tn += h;
        end
        LEVEL_NONE:   tn -= h;
        default: ;
      endcase
      if (mv > tn) level = LEVEL_NONE;
      else if (mv > tl) level = LEVEL_LOW;
      else if (mv > tm) level = LEVEL_MEDIUM;
      else level = LEVEL_HIGH;
      r.millivolts = MV_W'(mv);
      r.inhibit_level = level;
      r.strip_intact = ~s.strip_level;
      if (level == LEVEL_NONE && r.strip_intact) viol = VIOL_INHIBIT;
      else if (level != LEVEL_NONE && !r.strip_intact) viol = VIOL_STRIP;
      else viol = VIOL_NONE;
      r.violation = viol;
      r.violation_changed = (viol != last_viol);
      last_viol = viol;
      due_readings.push_back(r);
    endfunction

    function void note_fault(string field, int want, int got);
      faults++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_reading(result_t got);
      result_t want;
      if (due_readings.size() == 0) begin
        faults++;
        $display("%0t: unexpected reading, expected none, actual %p", $time, got);
        return;
      end
      want = due_readings.pop_front();
      if (got.millivolts !== want.millivolts)
        note_fault("millivolts", want.millivolts, got.millivolts);
      if (got.inhibit_level !== want.inhibit_level)
        note_fault("inhibit_level", want.inhibit_level, got.inhibit_level);
      if (got.strip_intact !== want.strip_intact)
        note_fault("strip_intact", want.strip_intact, got.strip_intact);
      if (got.violation !== want.violation)
        note_fault("violation", want.violation, got.violation);
      if (got.violation_changed !== want.violation_changed)
        note_fault("violation_changed", want.violation_changed, got.violation_changed);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  sample_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  result_t                out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [MV_W-1:0]        cfg_data = '0;

  reading_ledger ledger;
  bit            calm = 1'b0;
  int            group_pos;
  int            stall_cycles;

  adc_level_hysteresis_tamper_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) ledger.take_sample(in_data);
    if (!rst && out_valid && out_ready) ledger.check_reading(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MV_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.set_register(idx, val);
  endtask

  // stray writes land on an unused index and must leave the thresholds alone
  task automatic program_regs(input int tm, input int tl, input int tn, input int h,
                              input bit stray);
    if (stray) write_reg(CFG_INDEX_W'($urandom_range(4, 255)), MV_W'($urandom));
    write_reg(CFG_MEDIUM_TH, MV_W'(tm));
    write_reg(CFG_LOW_TH, MV_W'(tl));
    write_reg(CFG_NONE_TH, MV_W'(tn));
    write_reg(CFG_HYST, MV_W'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int clamp_raw(int v);
    if (v < 0) return 0;
    if (v > FULL_SCALE) return FULL_SCALE;
    return v;
  endfunction

  // groups mostly sit just either side of a threshold so hysteresis gets exercised
  task automatic send_random(input int n);
    sample_t s;
    int center, thr, hy, off;
    bit spread;
    for (int i = 0; i < n; i++) begin
      if (group_pos == 0) begin
        spread = ($urandom_range(0, 99) < 25);
        case ($urandom_range(0, 2))
          0: thr = ledger.medium_th;
          1: thr = ledger.low_th;
          default: thr = ledger.none_th;
        endcase
        hy = (ledger.hyst > 400) ? 400 : int'(ledger.hyst);
        off = int'($urandom_range(0, 2 * (hy + 40))) - (hy + 40);
        center = clamp_raw((thr + off) * FULL_SCALE / int'(VDD_MV));
      end
      s.raw_sample = spread ? RAW_W'($urandom)
                            : RAW_W'(clamp_raw(center + int'($urandom_range(0, 8)) - 4));
      s.strip_level = $urandom_range(0, 1);
      send_sample(s);
      group_pos = (group_pos + 1) % SAMPLES;
    end
  endtask

  initial begin
    sample_t s;
    int a, b, c;
    ledger = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full scale intact, zero cut, then mid-scale alternating extremes
    for (int i = 0; i < 3 * SAMPLES; i++) begin
      case (i / SAMPLES)
        0: s.raw_sample = RAW_W'(FULL_SCALE);
        1: s.raw_sample = '0;
        default: s.raw_sample = (i % 2) ? RAW_W'(FULL_SCALE) : '0;
      endcase
      s.strip_level = (i / SAMPLES) != 0;
      send_sample(s);
    end
    send_random(200);
    drain();

    program_regs(0, 0, 0, 0, 1'b1);
    send_random(123);
    drain();

    program_regs(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b0);
    send_random(120);
    drain();

    calm = 1'b1;
    program_regs($urandom_range(0, FULL_SCALE), $urandom_range(0, FULL_SCALE),
                 $urandom_range(0, FULL_SCALE), $urandom_range(0, 200), 1'b0);
    send_random(150);
    drain();
    calm = 1'b0;

    repeat (2) begin
      a = $urandom_range(0, 1000);
      b = $urandom_range(a, 2200);
      c = $urandom_range(b, 3300);
      program_regs(a, b, c, $urandom_range(0, 300), 1'b0);
      send_random(200);
      drain();
    end

    program_regs(MEDIUM_TH_RESET, LOW_TH_RESET, NONE_TH_RESET, HYST_RESET, 1'b1);
    send_random(150);
    in_valid <= 1'b0;
    drain();

    if (ledger.faults == 0 && ledger.due_readings.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/ahtm_pkg.sv
sv/ahtm_scale.sv
sv/adc_level_hysteresis_tamper_monitor.sv
tb/testbench.sv
